// ===== hw/rtl/bos_pkg.sv =====
// Package for the bounded ordered set: transfer payload types, operation codes,
// cell control struct and default capacity. No dependencies.
package bos_pkg;

  localparam int KEY_W            = 32;
  localparam int COUNT_W          = 5;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_REMOVE   = 2'd1;
  localparam logic [1:0] FUNC_CONTAINS = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic               stored;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic cmp;
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/bounded_ordered_set.sv =====
// Top level of the bounded ordered set: sequencer, count register, output
// register and the chain of cells. Depends on bos_pkg, bos_cell, bos_enc.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation (add,
//   remove, contains; code 3 acts as contains) and a 32-bit key. Output
//   channel out_valid/out_stall/out_data returns exactly one result per
//   operation: found (key present before), stored (add placed the key) and
//   the entry count afterwards.
//   An operation passes from its transfer to its result entering the output
//   register in turn: compare in every cell, encode the hit position,
//   then update (append at the count, or compact the cells right of the hit
//   one step left). The sequencer then returns to idle, where it takes the
//   next transfer. One operation is in flight at a time, so the next one is
//   accepted only after the update step of the last one.
//   The result sits in an output register; the next operation is accepted
//   while it waits. If the receiver stalls, the update step holds until the
//   output register is free, and in_stall stays high meanwhile.
//   Synchronous reset empties the set (count zero) and drops any pending
//   result; stored keys are not cleared.
module bounded_ordered_set #(
  parameter int CAPACITY = bos_pkg::DEFAULT_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bos_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bos_pkg::out_item_t out_data
);
  import bos_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_ENC,
    ST_UPD
  } state_t;

  state_t         state_r;
  logic [1:0]     func_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           found_r;
  logic [IW-1:0]  mpos_r;
  logic           out_valid_r;
  out_item_t      out_data_r;

  logic [CAPACITY-1:0] hits;
  logic [KEY_W-1:0]    entries [CAPACITY];
  logic                any_hit;
  logic [IW-1:0]       hit_pos;
  logic                upd_go;
  logic                add_ok;
  logic                rem_ok;
  cell_ctl_t           ctl;

  assign upd_go = (state_r == ST_UPD) && (!out_valid_r || !out_stall);
  assign add_ok = (func_r == FUNC_ADD) && !found_r && (count_r < CW'(CAPACITY));
  assign rem_ok = (func_r == FUNC_REMOVE) && found_r;

  always_comb begin
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign ctl.cmp   = (state_r == ST_CMP);
  assign ctl.shift = upd_go && rem_ok;
  assign ctl.wr    = upd_go && add_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_ENC;
        end
        ST_ENC: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_go) begin
            state_r <= ST_IDLE;
            count_r <= count_nxt;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      func_r <= in_data.func;
      key_r  <= in_data.key;
    end
    if (state_r == ST_ENC) begin
      found_r <= any_hit;
      mpos_r  <= hit_pos;
    end
    if (upd_go) begin
      out_data_r.found  <= found_r;
      out_data_r.stored <= add_ok;
      out_data_r.count  <= COUNT_W'(count_nxt);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_W-1:0] nxt;
    if (g == CAPACITY-1) begin : g_last
      assign nxt = entries[g];
    end else begin : g_mid
      assign nxt = entries[g+1];
    end
    bos_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (key_r),
      .count      (count_r),
      .mpos       (mpos_r),
      .next_entry (nxt),
      .entry      (entries[g]),
      .hit        (hits[g])
    );
  end

  bos_enc #(
    .CAPACITY (CAPACITY)
  ) u_enc (
    .hits    (hits),
    .any_hit (any_hit),
    .pos     (hit_pos)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENC) |-> $onehot0(hits))
    else $error("key matched in more than one cell");

  a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |=> (state_r == ST_ENC))
    else $error("compare step not followed by encode step");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && rem_ok) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not decrement count");

  a_store_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.stored) |-> !out_data_r.found)
    else $error("stored a key that was already present");
`endif

endmodule

// ===== hw/rtl/bos_cell.sv =====
// One storage cell of the set chain: holds one key, compares it with the
// operation key and takes its right neighbor's key when the chain compacts.
// Depends on bos_pkg.
module bos_cell #(
  parameter int CAPACITY = bos_pkg::DEFAULT_CAPACITY,
  parameter int IDX      = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bos_pkg::cell_ctl_t          ctl,
  input  logic [bos_pkg::KEY_W-1:0]   key,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mpos,
  input  logic [bos_pkg::KEY_W-1:0]   next_entry,
  output logic [bos_pkg::KEY_W-1:0]   entry,
  output logic                        hit
);
  import bos_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KEY_W-1:0] entry_r;
  logic             hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.cmp) begin
      hit_r <= (entry_r == key) && (CW'(IDX) < count);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && (CW'(IDX) == count)) begin
      entry_r <= key;
    end else if (ctl.shift && (IW'(IDX) >= mpos)) begin
      entry_r <= next_entry;
    end
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

// ===== hw/rtl/bos_enc.sv =====
// Hit encoder for the set chain: reduces the per-cell hit bits to a found
// flag and the position of the matching cell. Depends on bos_pkg.
module bos_enc #(
  parameter int CAPACITY = bos_pkg::DEFAULT_CAPACITY
) (
  input  logic [CAPACITY-1:0] hits,
  output logic                any_hit,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] pos
);
  import bos_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  always_comb begin
    logic [IW-1:0] idx;
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      idx = IW'(i);
      if (hits[i]) begin
        pos = pos | idx;
      end
    end
  end

  assign any_hit = |hits;

endmodule
